[design/pdd_pkg.sv]
// ----------------------------------------------------------------------------
// pdd_pkg: shared definitions for the pulse discriminator with dead time
// Register indexes, reset values, field widths and the result record.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int unsigned AmpW     = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgDead      = 2'd1,
    CfgWidth     = 2'd2,
    CfgUnused    = 2'd3
  } cfg_idx_e;

  localparam logic signed [AmpW-1:0] ThresholdReset = 16'sd0;
  localparam logic [CntW-1:0]        DeadReset      = 16'd5;
  localparam logic [CntW-1:0]        WidthReset     = 16'd10;
  localparam logic [CntW-1:0]        CntMax         = 16'hFFFF;

  typedef struct packed {
    logic [CntW-1:0] pulse_count;
    logic [CntW-1:0] start_interval;
    logic            pulse_start;
    logic            disc_level;
  } result_t;

endpackage

[design/pulse_discriminator_deadtime.sv]
// ----------------------------------------------------------------------------
// pulse_discriminator_deadtime: leading-edge discriminator with dead time
// Compares each sample with a threshold, enforces dead time and minimum
// output width, and reports pulse starts, start intervals and pulse counts.
// ----------------------------------------------------------------------------
// An accepted sample's result is registered in the output register.
// Throughput: one sample per cycle unless the output stalls; the state update is combinational.
// The input side is ready whenever the output register is empty or being taken.
// Reset: rst_ni clears the waveform state and the output valid flag, and loads
// the register reset values (threshold 0, dead time 5, width 10).
module pulse_discriminator_deadtime #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pdd_pkg::CfgDataW-1:0]    cfg_data_i,
  // Sample stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: amplitude[15:0].
  input  logic [pdd_pkg::AmpW-1:0]        s_axis_tdata_i,
  // last_sample.
  input  logic                            s_axis_tlast_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: disc_level[0], pulse_start[1], start_interval[17:2],
  // pulse_count[33:18], zero fill [39:34].
  output logic [pdd_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  localparam int unsigned CmpW = (INDEX_BITS > 16) ? INDEX_BITS : 16;
  localparam logic [INDEX_BITS-1:0] IdxMax = {INDEX_BITS{1'b1}};

  logic signed [pdd_pkg::AmpW-1:0] threshold_q;
  logic [pdd_pkg::CntW-1:0]        dead_q;
  logic [pdd_pkg::CntW-1:0]        width_q;

  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [INDEX_BITS-1:0] on_idx_q, on_idx_d;
  logic [INDEX_BITS-1:0] off_idx_q, off_idx_d;
  logic [INDEX_BITS-1:0] prev_q, prev_d;
  logic [pdd_pkg::CntW-1:0] count_q, count_d;
  logic on_q, on_d;
  logic on_seen_q, on_seen_d;
  logic off_seen_q, off_seen_d;

  logic                out_valid_q;
  pdd_pkg::result_t    res_q, res_d;

  logic            accept;
  logic            high;
  logic            dead_ok;
  logic            width_ok;
  logic            on_event;
  logic            off_event;
  logic [CmpW-1:0] since_off;
  logic [CmpW-1:0] since_on;
  logic [CmpW-1:0] since_start;
  logic [pdd_pkg::CntW-1:0] count_next;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(pdd_pkg::OutDataW - $bits(pdd_pkg::result_t)){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= pdd_pkg::ThresholdReset;
      dead_q      <= pdd_pkg::DeadReset;
      width_q     <= pdd_pkg::WidthReset;
    end else if (cfg_valid_i) begin
      unique case (pdd_pkg::cfg_idx_e'(cfg_index_i))
        pdd_pkg::CfgThreshold: threshold_q <= $signed(cfg_data_i);
        pdd_pkg::CfgDead:      dead_q      <= cfg_data_i;
        pdd_pkg::CfgWidth:     width_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    since_off   = CmpW'(idx_q - off_idx_q);
    since_on    = CmpW'(idx_q - on_idx_q);
    since_start = CmpW'(idx_q - prev_q);
    high        = $signed(s_axis_tdata_i) >= threshold_q;
    dead_ok     = !off_seen_q || (since_off >= CmpW'(dead_q));
    width_ok    = !on_seen_q || (since_on >= CmpW'(width_q));
    on_event    = high && dead_ok && !on_q;
    off_event   = !high && width_ok && on_q;
    count_next  = (on_event && (count_q != pdd_pkg::CntMax)) ? count_q + 1'b1 : count_q;

    res_d.disc_level     = high ? dead_ok : !width_ok;
    res_d.pulse_start    = on_event;
    res_d.pulse_count    = count_next;
    res_d.start_interval = '0;
    if (on_event) begin
      res_d.start_interval = (since_start > CmpW'(pdd_pkg::CntMax)) ?
                             pdd_pkg::CntMax : since_start[pdd_pkg::CntW-1:0];
    end

    idx_d      = (idx_q != IdxMax) ? idx_q + 1'b1 : idx_q;
    on_d       = on_q;
    on_seen_d  = on_seen_q || on_event;
    off_seen_d = off_seen_q || off_event;
    on_idx_d   = on_event ? idx_q : on_idx_q;
    prev_d     = on_event ? idx_q : prev_q;
    off_idx_d  = off_event ? idx_q : off_idx_q;
    count_d    = count_next;
    if (high && dead_ok) begin
      on_d = 1'b1;
    end else if (!high && width_ok) begin
      on_d = 1'b0;
    end

    if (s_axis_tlast_i) begin
      idx_d      = '0;
      on_d       = 1'b0;
      on_seen_d  = 1'b0;
      off_seen_d = 1'b0;
      on_idx_d   = '0;
      off_idx_d  = '0;
      prev_d     = '0;
      count_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      on_idx_q   <= '0;
      off_idx_q  <= '0;
      prev_q     <= '0;
      count_q    <= '0;
      on_q       <= 1'b0;
      on_seen_q  <= 1'b0;
      off_seen_q <= 1'b0;
    end else if (accept) begin
      idx_q      <= idx_d;
      on_idx_q   <= on_idx_d;
      off_idx_q  <= off_idx_d;
      prev_q     <= prev_d;
      count_q    <= count_d;
      on_q       <= on_d;
      on_seen_q  <= on_seen_d;
      off_seen_q <= off_seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

[tb/pdd_checker.sv]
// ----------------------------------------------------------------------------
// pdd_checker: result checker for the pulse discriminator with dead time
// Watches the configuration channel, the sample stream and the result stream, keeps its own
// copy of the registers and waveform state, predicts one result per
// accepted sample and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module pdd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [pdd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pdd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // Fields from bit 0: amplitude[15:0].
  input  logic [pdd_pkg::AmpW-1:0]        s_axis_tdata_i,
  // last_sample.
  input  logic                            s_axis_tlast_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: disc_level, pulse_start, start_interval, pulse_count.
  input  logic [pdd_pkg::OutDataW-1:0]    m_axis_tdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  typedef logic [15:0] sample_idx_t;

  logic signed [pdd_pkg::AmpW-1:0] threshold_q;
  logic [pdd_pkg::CntW-1:0]        dead_q;
  logic [pdd_pkg::CntW-1:0]        width_q;

  sample_idx_t              idx_q;
  sample_idx_t              on_idx_q;
  sample_idx_t              off_idx_q;
  sample_idx_t              prev_start_q;
  logic                     on_q;
  logic                     on_seen_q;
  logic                     off_seen_q;
  logic [pdd_pkg::CntW-1:0] count_q;

  pdd_pkg::result_t expected_results[$];
  int unsigned      fails = 0;

  assign fail_count_o = fails;

  task automatic clear_waveform();
    idx_q        = '0;
    on_idx_q     = '0;
    off_idx_q    = '0;
    prev_start_q = '0;
    on_q         = 1'b0;
    on_seen_q    = 1'b0;
    off_seen_q   = 1'b0;
    count_q      = '0;
  endtask

  task automatic discriminate(input logic signed [pdd_pkg::AmpW-1:0] amp,
                              input logic last);
    pdd_pkg::result_t r;
    sample_idx_t      i;
    r = '0;
    i = idx_q;
    if (amp >= threshold_q) begin
      if (!off_seen_q || sample_idx_t'(i - off_idx_q) >= dead_q) begin
        if (!on_q) begin
          r.pulse_start    = 1'b1;
          r.start_interval = i - prev_start_q;
          prev_start_q     = i;
          if (count_q != pdd_pkg::CntMax) count_q++;
          on_idx_q  = i;
          on_seen_q = 1'b1;
        end
        on_q         = 1'b1;
        r.disc_level = 1'b1;
      end
    end else if (!on_seen_q || sample_idx_t'(i - on_idx_q) >= width_q) begin
      if (on_q) begin
        off_idx_q  = i;
        off_seen_q = 1'b1;
      end
      on_q = 1'b0;
    end else begin
      r.disc_level = 1'b1;
    end
    r.pulse_count = count_q;
    expected_results = {expected_results, r};
    if (idx_q != '1) idx_q++;
    if (last) clear_waveform();
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  task automatic check_result(input pdd_pkg::result_t got);
    pdd_pkg::result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("Result arrived with no request outstanding.");
      fails++;
    end else begin
      exp_r = expected_results.pop_front();
      check_field("disc_level", exp_r.disc_level, got.disc_level);
      check_field("pulse_start", exp_r.pulse_start, got.pulse_start);
      check_field("start_interval", exp_r.start_interval, got.start_interval);
      check_field("pulse_count", exp_r.pulse_count, got.pulse_count);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q = pdd_pkg::ThresholdReset;
      dead_q      = pdd_pkg::DeadReset;
      width_q     = pdd_pkg::WidthReset;
      clear_waveform();
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (pdd_pkg::cfg_idx_e'(cfg_index_i))
          pdd_pkg::CfgThreshold: threshold_q = cfg_data_i;
          pdd_pkg::CfgDead:      dead_q      = cfg_data_i;
          pdd_pkg::CfgWidth:     width_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_result(pdd_pkg::result_t'(m_axis_tdata_i[$bits(pdd_pkg::result_t)-1:0]));
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        discriminate($signed(s_axis_tdata_i), s_axis_tlast_i);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

[tb/tb_pulse_discriminator_deadtime.sv]
// ----------------------------------------------------------------------------
// tb_pulse_discriminator_deadtime: testbench for the pulse discriminator
// Drives directed and random waveforms under several register settings,
// including one longer waveform of alternating samples,
// with random idle bursts and one long output stall; the checker compares.
// ----------------------------------------------------------------------------
module tb_pulse_discriminator_deadtime;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [pdd_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [pdd_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [pdd_pkg::AmpW-1:0]     s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [pdd_pkg::OutDataW-1:0] m_tdata;
  int unsigned                  fail_count;
  int unsigned                  pending;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;
  int thr_cur    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pulse_discriminator_deadtime uut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  pdd_checker checker_i (
    .clk_i,
    .rst_ni,
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    #400000;
    $display("tb_pulse_discriminator_deadtime failed");
    $finish;
  end

  // The receiver stalls in short random bursts, or for a long stretch on request.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic int high_amp();
    return int'($urandom_range(thr_cur + 32768, 65535)) - 32768;
  endfunction

  function automatic int low_amp();
    if (thr_cur == -32768) return high_amp();
    return int'($urandom_range(0, thr_cur + 32767)) - 32768;
  endfunction

  task automatic send_sample(input int amp, input bit last);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= amp[pdd_pkg::AmpW-1:0];
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic configure(input int thr, input int dead, input int width);
    pdd_pkg::cfg_idx_e idx_l[4];
    logic [15:0]       val_l[4];
    idx_l = '{pdd_pkg::CfgThreshold, pdd_pkg::CfgDead, pdd_pkg::CfgWidth,
              pdd_pkg::CfgUnused};
    val_l = '{thr[15:0], dead[15:0], width[15:0], 16'($urandom)};
    drain();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_l[k];
      cfg_data  <= val_l[k];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    thr_cur = thr;
  endtask

  // Runs of high and low samples around the threshold, with some noise.
  task automatic send_waveform(input int len, input bit close);
    bit hi;
    int run;
    int amp;
    hi  = $urandom_range(0, 1);
    run = 0;
    for (int k = 0; k < len; k++) begin
      if (run == 0) begin
        hi  = !hi;
        run = $urandom_range(1, 8);
      end
      run--;
      amp = hi ? high_amp() : low_amp();
      case ($urandom_range(0, 19))
        0, 1: amp = int'($urandom_range(0, 65535)) - 32768;
        2:    amp = 32767;
        3:    amp = -32768;
        4:    amp = thr_cur;
        default: ;
      endcase
      send_sample(amp, close && k == len - 1);
    end
  endtask

  task automatic run_phase(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      send_waveform(len, $urandom_range(0, 5) != 0);
      sent += len;
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: first pulse, low within width, extreme low.
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(-32768, 1'b1);

    configure(100, 3, 2);
    send_sample(-32768, 1'b0);
    send_sample(99, 1'b0);
    send_sample(100, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(200, 1'b0);
    send_sample(150, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(0, 1'b1);
    send_sample(100, 1'b0);
    send_sample(100, 1'b1);

    configure(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 8),
              $urandom_range(0, 8));
    run_phase(90);
    configure(-32768, 0, 0);
    run_phase(90);
    configure(32767, 65535, 65535);
    run_phase(90);
    configure(0, 0, 0);
    run_phase(90);
    configure(int'($urandom_range(0, 65535)) - 32768, 65535, 0);
    run_phase(90);
    configure(int'($urandom_range(0, 65535)) - 32768, 0, 65535);
    run_phase(90);

    configure(int'($urandom_range(0, 400)) - 200, $urandom_range(0, 15),
              $urandom_range(0, 15));
    hold_req = 1'b1;
    run_phase(90);

    // One longer waveform of alternating high and low samples.
    configure(0, 0, 0);
    tx_idle_en = 1'b0;
    for (int k = 0; k < 200; k++) begin
      send_sample((k % 2 == 0) ? high_amp() : low_amp(), k == 199);
    end
    tx_idle_en = 1'b1;

    configure(int'($urandom_range(0, 400)) - 200, $urandom_range(0, 12),
              $urandom_range(0, 12));
    run_phase(60);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(100);

    drain();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_pulse_discriminator_deadtime passed");
    end else begin
      $display("tb_pulse_discriminator_deadtime failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pdd_pkg.sv
design/pulse_discriminator_deadtime.sv
tb/pdd_checker.sv
tb/tb_pulse_discriminator_deadtime.sv
